@@ rtl/mbw_pkg.sv @@
// Package for the maze backtracker walk.
// Holds payload widths, event and direction codes and the direction shuffle.
// No dependencies.
package mbw_pkg;

    // Default grid size
    localparam int GRID_COLS_DEF = 16;
    localparam int GRID_ROWS_DEF = 8;

    // Payload widths of the channels
    localparam int KIND_W = 2;
    localparam int COL_W  = 4;
    localparam int ROW_W  = 3;
    localparam int DIR_W  = 2;

    // Event codes of a result transaction
    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_CARVE  = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    // Move directions from a parent cell
    typedef enum logic [DIR_W-1:0] {
        DIR_COL_INC = 2'd0,
        DIR_COL_DEC = 2'd1,
        DIR_ROW_INC = 2'd2,
        DIR_ROW_DEC = 2'd3
    } dir_t;

    // Fisher-Yates shuffle of the four directions; entry i sits at [2i+1:2i]
    function automatic logic [7:0] shuffle_dirs(
        input logic [1:0] pick4,
        input logic [1:0] pick3,
        input logic       pick2
    );
        logic [1:0] ord [4];
        logic [1:0] tmp;
        logic [1:0] j3;
        ord[0] = DIR_COL_INC;
        ord[1] = DIR_COL_DEC;
        ord[2] = DIR_ROW_INC;
        ord[3] = DIR_ROW_DEC;
        tmp        = ord[3];
        ord[3]     = ord[pick4];
        ord[pick4] = tmp;
        // pick of three wraps: three acts as zero
        j3      = (pick3 == 2'd3) ? 2'd0 : pick3;
        tmp     = ord[2];
        ord[2]  = ord[j3];
        ord[j3] = tmp;
        tmp                 = ord[1];
        ord[1]              = ord[{1'b0, pick2}];
        ord[{1'b0, pick2}]  = tmp;
        return {ord[3], ord[2], ord[1], ord[0]};
    endfunction

endpackage

@@ rtl/mbw_if.sv @@
// Channel interfaces of the maze backtracker walk.
// Step channel carries restart and shuffle picks; report channel carries events.
// Depends on mbw_pkg.
interface mbw_step_if
    import mbw_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       restart;
    logic [1:0] pick_of_four;
    logic [1:0] pick_of_three;
    logic       pick_of_two;

    modport source (output valid, restart, pick_of_four, pick_of_three, pick_of_two,
                    input ready);
    modport sink   (input valid, restart, pick_of_four, pick_of_three, pick_of_two,
                    output ready);
endinterface

interface mbw_report_if
    import mbw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic [DIR_W-1:0]  came_from_dir;

    modport source (output valid, event_kind, cell_col, cell_row, came_from_dir,
                    input ready);
    modport sink   (input valid, event_kind, cell_col, cell_row, came_from_dir,
                    output ready);
endinterface

@@ rtl/maze_backtracker_walk.sv @@
// Maze backtracker walk: randomized depth-first maze carving with a frame stack.
// A walk step loads the top frame, then tries its directions in shuffled order,
// reads the visited map for each in-grid one and pops exhausted frames, until it
// carves a cell or the stack is empty. The frame and visited memory ports serialize the
// search. A restart sweeps the visited memory.
// One step transaction at a time. Reset empties the stack and the report register.
// Depends on mbw_pkg and mbw_if.
module maze_backtracker_walk
    import mbw_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    mbw_step_if.sink     step,
    mbw_report_if.source report
);

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int IW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int FW    = CW + RW + 8 + 3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_START = 7'b0000100,
        ST_LOAD  = 7'b0001000,
        ST_TRY   = 7'b0010000,
        ST_VIS   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Memories
    logic          visited_mem [CELLS];
    logic [FW-1:0] frame_mem   [CELLS];

    logic          vis_we, vis_wdata, vis_re, vis_rdata_reg;
    logic [IW-1:0] vis_waddr, vis_raddr;
    logic          frm_we, frm_re;
    logic [IW-1:0] frm_waddr, frm_raddr;
    logic [FW-1:0] frm_wdata, frm_rdata_reg;

    // Control and working registers
    logic [CNTW-1:0] count_reg, count_next;
    logic [IW-1:0]   clr_addr_reg, clr_addr_next;
    logic [1:0]      pick4_reg, pick3_reg;
    logic            pick2_reg;
    logic [CW-1:0]   top_col_reg, top_col_next;
    logic [RW-1:0]   top_row_reg, top_row_next;
    logic [7:0]      top_order_reg, top_order_next;
    logic [2:0]      top_tried_reg, top_tried_next;
    logic [CW-1:0]   nb_col_reg, nb_col_next;
    logic [RW-1:0]   nb_row_reg, nb_row_next;
    logic [1:0]      nb_dir_reg, nb_dir_next;

    // Pending result and report register
    kind_t           res_kind_reg, res_kind_next;
    logic [CW-1:0]   res_col_reg, res_col_next;
    logic [RW-1:0]   res_row_reg, res_row_next;
    logic [1:0]      res_dir_reg, res_dir_next;
    logic            out_valid_reg;
    logic            out_load;
    logic [KIND_W-1:0] out_kind_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [DIR_W-1:0]  out_dir_reg;

    // Neighbor of the top frame
    logic [1:0]    cur_dir;
    logic          off_grid;
    logic [CW-1:0] cand_col;
    logic [RW-1:0] cand_row;
    logic [7:0]    new_order;
    logic [IW-1:0] top_addr, below_addr, push_addr, cand_addr;
    logic          step_take;

    assign step_take  = step.valid && step.ready;
    assign step.ready = (state_reg == ST_IDLE);

    assign top_addr   = IW'(count_reg - CNTW'(1));
    assign below_addr = IW'(count_reg - CNTW'(2));
    assign push_addr  = IW'(count_reg);
    assign new_order  = shuffle_dirs(pick4_reg, pick3_reg, pick2_reg);
    assign cur_dir    = top_order_reg[{top_tried_reg[1:0], 1'b0} +: 2];
    assign cand_addr  = IW'(IW'(cand_row) * IW'(GRID_COLS) + IW'(cand_col));

    // Step one cell in the chosen direction and flag moves off the grid
    always_comb
    begin
        cand_col = top_col_reg;
        cand_row = top_row_reg;
        off_grid = 1'b0;
        unique case (cur_dir)
            DIR_COL_INC:
            begin
                cand_col = top_col_reg + CW'(1);
                off_grid = (top_col_reg == CW'(GRID_COLS - 1));
            end
            DIR_COL_DEC:
            begin
                cand_col = top_col_reg - CW'(1);
                off_grid = (top_col_reg == '0);
            end
            DIR_ROW_INC:
            begin
                cand_row = top_row_reg + RW'(1);
                off_grid = (top_row_reg == RW'(GRID_ROWS - 1));
            end
            DIR_ROW_DEC:
            begin
                cand_row = top_row_reg - RW'(1);
                off_grid = (top_row_reg == '0);
            end
            default:
            begin
                off_grid = 1'b1;
            end
        endcase
    end

    // Walk sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        clr_addr_next  = clr_addr_reg;
        top_col_next   = top_col_reg;
        top_row_next   = top_row_reg;
        top_order_next = top_order_reg;
        top_tried_next = top_tried_reg;
        nb_col_next    = nb_col_reg;
        nb_row_next    = nb_row_reg;
        nb_dir_next    = nb_dir_reg;
        res_kind_next  = res_kind_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        res_dir_next   = res_dir_reg;
        out_load       = 1'b0;
        vis_we         = 1'b0;
        vis_waddr      = clr_addr_reg;
        vis_wdata      = 1'b0;
        vis_re         = 1'b0;
        vis_raddr      = cand_addr;
        frm_we         = 1'b0;
        frm_waddr      = top_addr;
        frm_wdata      = {top_col_reg, top_row_reg, top_order_reg, top_tried_reg + 3'd1};
        frm_re         = 1'b0;
        frm_raddr      = top_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_take)
                begin
                    if (step.restart)
                    begin
                        clr_addr_next = '0;
                        count_next    = '0;
                        state_next    = ST_CLEAR;
                    end
                    else if (count_reg == '0)
                    begin
                        res_kind_next = KIND_FINISH;
                        res_col_next  = '0;
                        res_row_next  = '0;
                        res_dir_next  = '0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        frm_re     = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_CLEAR:
            begin
                // sweep the visited map, one cell a cycle
                vis_we = 1'b1;
                clr_addr_next = clr_addr_reg + IW'(1);
                if (clr_addr_reg == IW'(CELLS - 1))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                // open cell (0,0) as the first frame
                vis_we        = 1'b1;
                vis_waddr     = '0;
                vis_wdata     = 1'b1;
                frm_we        = 1'b1;
                frm_waddr     = '0;
                frm_wdata     = {CW'(0), RW'(0), new_order, 3'd0};
                count_next    = CNTW'(1);
                res_kind_next = KIND_START;
                res_col_next  = '0;
                res_row_next  = '0;
                res_dir_next  = '0;
                state_next    = ST_DONE;
            end
            ST_LOAD:
            begin
                {top_col_next, top_row_next, top_order_next, top_tried_next} = frm_rdata_reg;
                state_next = ST_TRY;
            end
            ST_TRY:
            begin
                if (top_tried_reg[2])
                begin
                    // frame exhausted: pop it
                    count_next = count_reg - CNTW'(1);
                    if (count_reg == CNTW'(1))
                    begin
                        res_kind_next = KIND_FINISH;
                        res_col_next  = '0;
                        res_row_next  = '0;
                        res_dir_next  = '0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        frm_re     = 1'b1;
                        frm_raddr  = below_addr;
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    // consume one direction and write the frame back
                    frm_we         = 1'b1;
                    top_tried_next = top_tried_reg + 3'd1;
                    nb_col_next    = cand_col;
                    nb_row_next    = cand_row;
                    nb_dir_next    = cur_dir;
                    if (!off_grid)
                    begin
                        vis_re     = 1'b1;
                        state_next = ST_VIS;
                    end
                end
            end
            ST_VIS:
            begin
                if (vis_rdata_reg)
                begin
                    state_next = ST_TRY;
                end
                else
                begin
                    // carve into the new cell and push its frame
                    vis_we        = 1'b1;
                    vis_waddr     = IW'(IW'(nb_row_reg) * IW'(GRID_COLS) + IW'(nb_col_reg));
                    vis_wdata     = 1'b1;
                    frm_we        = 1'b1;
                    frm_waddr     = push_addr;
                    frm_wdata     = {nb_col_reg, nb_row_reg, new_order, 3'd0};
                    count_next    = count_reg + CNTW'(1);
                    res_kind_next = KIND_CARVE;
                    res_col_next  = nb_col_reg;
                    res_row_next  = nb_row_reg;
                    res_dir_next  = nb_dir_reg;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hand the result over once the report register is free
                if (!out_valid_reg || report.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        clr_addr_reg  <= clr_addr_next;
        top_col_reg   <= top_col_next;
        top_row_reg   <= top_row_next;
        top_order_reg <= top_order_next;
        top_tried_reg <= top_tried_next;
        nb_col_reg    <= nb_col_next;
        nb_row_reg    <= nb_row_next;
        nb_dir_reg    <= nb_dir_next;
        res_kind_reg  <= res_kind_next;
        res_col_reg   <= res_col_next;
        res_row_reg   <= res_row_next;
        res_dir_reg   <= res_dir_next;
        if (step_take)
        begin
            pick4_reg <= step.pick_of_four;
            pick3_reg <= step.pick_of_three;
            pick2_reg <= step.pick_of_two;
        end
        if (out_load)
        begin
            out_kind_reg <= res_kind_reg;
            out_col_reg  <= COL_W'({{COL_W{1'b0}}, res_col_reg});
            out_row_reg  <= ROW_W'({{ROW_W{1'b0}}, res_row_reg});
            out_dir_reg  <= res_dir_reg;
        end
    end

    // Visited map memory
    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            visited_mem[vis_waddr] <= vis_wdata;
        end
        if (vis_re)
        begin
            vis_rdata_reg <= visited_mem[vis_raddr];
        end
    end

    // Frame stack memory
    always_ff @(posedge clk)
    begin
        if (frm_we)
        begin
            frame_mem[frm_waddr] <= frm_wdata;
        end
        if (frm_re)
        begin
            frm_rdata_reg <= frame_mem[frm_raddr];
        end
    end

    assign report.valid         = out_valid_reg;
    assign report.event_kind    = out_kind_reg;
    assign report.cell_col      = out_col_reg;
    assign report.cell_row      = out_row_reg;
    assign report.came_from_dir = out_dir_reg;

endmodule
